// ===== rtl/e2q_pkg.sv =====
// Package for the Euler angle to quaternion unit.
// Holds angle constants and the CORDIC arctangent table. No dependencies.
package e2q_pkg;

	localparam int TABLE_LEN = 24;
	localparam int ANG_W = 34;
	localparam int ANG_FRAC = 30;
	localparam int OUT_FRAC = 14;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [ANG_W-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [63:0] GAIN_Q30 = 64'sd652032874;
	localparam logic signed [16:0] OUT_MAX = 17'sd16384;

	function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
		logic signed [ANG_W-1:0] r;
		case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: r = ANG_W'(64'sd1 <<< (30 - i));
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/e2q_cordic.sv =====
// Pipelined rotation-mode CORDIC lane: sine and cosine of half an angle.
// Depends on e2q_pkg. One angle per cycle.
module e2q_cordic import e2q_pkg::*; #(
	parameter int ITER = 16,
	parameter int DW = 16
) (
	input  logic                 clk,
	input  logic signed [15:0]   angle,
	output logic signed [DW-1:0] cos_out,
	output logic signed [DW-1:0] sin_out
);
	localparam int F = DW - 2;
	localparam int XW = DW + 1;
	localparam logic signed [63:0] X0 =
		(GAIN_Q30 + (64'sd1 <<< (ANG_FRAC - F - 1))) >>> (ANG_FRAC - F);

	logic signed [XW-1:0]    x_s [ITER+1];
	logic signed [XW-1:0]    y_s [ITER+1];
	logic signed [ANG_W-1:0] z_s [ITER+1];
	logic                    neg_s [ITER+1];
	logic signed [ANG_W-1:0] z_in;

	assign z_in = ANG_W'(angle) <<< 16;

	always_ff @(posedge clk) begin
		x_s[0] <= XW'(X0);
		y_s[0] <= '0;
		if (z_in > HALF_PI_Q30) begin
			z_s[0] <= PI_Q30 - z_in;
			neg_s[0] <= 1'b1;
		end else if (z_in < -HALF_PI_Q30) begin
			z_s[0] <= -PI_Q30 - z_in;
			neg_s[0] <= 1'b1;
		end else begin
			z_s[0] <= z_in;
			neg_s[0] <= 1'b0;
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_it
		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			if (!z_s[i][ANG_W-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_q30(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_q30(i);
			end
		end
	end

	assign cos_out = neg_s[ITER] ? DW'(-x_s[ITER]) : DW'(x_s[ITER]);
	assign sin_out = DW'(y_s[ITER]);
endmodule

// ===== rtl/e2q_merge.sv =====
// Merging stage: triple products of the three lanes' pairs, rescale, saturate.
// Depends on e2q_pkg. Fully pipelined.
module e2q_merge import e2q_pkg::*; #(
	parameter int DW = 16
) (
	input  logic                 clk,
	input  logic signed [DW-1:0] cr, sr, cp, sp, cy, sy,
	output logic signed [15:0]   qx, qy, qz, qw
);
	localparam int F = DW - 2;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] cc_s1, cs_s1, sc_s1, ss_s1, cy_s1, sy_s1;
	logic signed [DW-1:0] t_s2 [8];
	logic signed [15:0] q_s3 [4];

	function automatic logic signed [DW-1:0] mq(input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b);
		logic signed [PW-1:0] p;
		p = PW'(a) * PW'(b);
		p = p + (PW'(1) <<< (F - 1));
		return DW'(p >>> F);
	endfunction

	function automatic logic signed [15:0] sat(input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b, input logic sub);
		logic signed [DW+OUT_FRAC:0] v;
		v = sub ? (DW+OUT_FRAC+1)'(a) - (DW+OUT_FRAC+1)'(b)
			: (DW+OUT_FRAC+1)'(a) + (DW+OUT_FRAC+1)'(b);
		if (F >= OUT_FRAC) begin
			if (F > OUT_FRAC) v = (v + ((DW+OUT_FRAC+1)'(1) <<< (F - OUT_FRAC - 1)))
				>>> (F - OUT_FRAC);
		end else begin
			v = v <<< (OUT_FRAC - F);
		end
		if (v > OUT_MAX) v = OUT_MAX;
		if (v < -OUT_MAX) v = -OUT_MAX;
		return 16'(v);
	endfunction

	always_ff @(posedge clk) begin
		cc_s1 <= mq(cr, cp);
		cs_s1 <= mq(cr, sp);
		sc_s1 <= mq(sr, cp);
		ss_s1 <= mq(sr, sp);
		cy_s1 <= cy;
		sy_s1 <= sy;
		t_s2[0] <= mq(sc_s1, cy_s1);
		t_s2[1] <= mq(cs_s1, sy_s1);
		t_s2[2] <= mq(cs_s1, cy_s1);
		t_s2[3] <= mq(sc_s1, sy_s1);
		t_s2[4] <= mq(cc_s1, sy_s1);
		t_s2[5] <= mq(ss_s1, cy_s1);
		t_s2[6] <= mq(cc_s1, cy_s1);
		t_s2[7] <= mq(ss_s1, sy_s1);
		q_s3[0] <= sat(t_s2[0], t_s2[1], 1'b1);
		q_s3[1] <= sat(t_s2[2], t_s2[3], 1'b0);
		q_s3[2] <= sat(t_s2[4], t_s2[5], 1'b1);
		q_s3[3] <= sat(t_s2[6], t_s2[7], 1'b0);
	end

	assign qx = q_s3[0];
	assign qy = q_s3[1];
	assign qz = q_s3[2];
	assign qw = q_s3[3];
endmodule

// ===== rtl/euler_to_quaternion_unit.sv =====
// Euler angles (ZYX) to unit quaternion: three CORDIC lanes and a merge stage.
// One item per cycle.
// The throughput is set by the fully unrolled CORDIC pipeline; busy stays low.
// Reset clears only the done strobe pipeline; data stages need no reset.
// The receiver cannot stall: each result is shown for one cycle with done.
module euler_to_quaternion_unit import e2q_pkg::*; #(
	parameter int CORDIC_ITERATIONS = 16,
	parameter int DATA_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	output logic               done,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);
	localparam int LAT = CORDIC_ITERATIONS + 4;

	logic signed [DATA_WIDTH-1:0] cr, sr, cp, sp, cy, sy;
	logic [LAT-1:0] vld_q;

	assign busy = 1'b0;

	e2q_cordic #(.ITER(CORDIC_ITERATIONS), .DW(DATA_WIDTH)) u_roll (
		.clk(clk), .angle(roll_angle), .cos_out(cr), .sin_out(sr));
	e2q_cordic #(.ITER(CORDIC_ITERATIONS), .DW(DATA_WIDTH)) u_pitch (
		.clk(clk), .angle(pitch_angle), .cos_out(cp), .sin_out(sp));
	e2q_cordic #(.ITER(CORDIC_ITERATIONS), .DW(DATA_WIDTH)) u_yaw (
		.clk(clk), .angle(yaw_angle), .cos_out(cy), .sin_out(sy));

	e2q_merge #(.DW(DATA_WIDTH)) u_merge (
		.clk(clk), .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
		.qx(quat_x), .qy(quat_y), .qz(quat_z), .qw(quat_w));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	assign done = vld_q[LAT-1];
endmodule

// ===== bench/tb_top.sv =====
// Testbench for euler_to_quaternion_unit: directed and random angle triples.
// Predicts each quaternion in fixed point and checks every done transfer in order.
// Depends on rtl/e2q_pkg.sv and rtl/euler_to_quaternion_unit.sv.

typedef struct {
	logic signed [15:0] qx;
	logic signed [15:0] qy;
	logic signed [15:0] qz;
	logic signed [15:0] qw;
} quat_t;

class quat_scoreboard;
	quat_t pending[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	static function longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	static function longint round_sh(longint v, int s);
		if (s == 0) return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	static function longint atan_entry(int i);
		longint tbl[24] = '{843314857, 497837829, 263043837, 133525159,
			67021687, 33543516, 16775851, 8388437, 4194283, 2097149,
			1048576, 524288, 262144, 131072, 65536, 32768, 16384, 8192,
			4096, 2048, 1024, 512, 256, 128};
		return tbl[i];
	endfunction

	// Cosine and sine of half the angle, Q14 with the 16-bit data path.
	static function void half_trig(logic signed [15:0] ang, output longint c,
			output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'(ang) * 65536;
		flip = 0;
		if (z > 64'sd1686629713) begin
			z = 64'sd3373259426 - z; flip = 1;
		end else if (z < -64'sd1686629713) begin
			z = -64'sd3373259426 - z; flip = 1;
		end
		x = round_sh(652032874, 30 - 14);
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = floor_sh(y, i);
			dy = floor_sh(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_entry(i);
			end else begin
				x += dx; y -= dy; z += atan_entry(i);
			end
		end
		c = flip ? -x : x;
		s = y;
	endfunction

	static function longint mul3(longint a, longint b, longint c);
		return round_sh(round_sh(a * b, 14) * c, 14);
	endfunction

	static function logic signed [15:0] sat(longint v);
		if (v > 16384) v = 16384;
		if (v < -16384) v = -16384;
		return 16'(v);
	endfunction

	function void note_angles(logic signed [15:0] r, logic signed [15:0] p,
			logic signed [15:0] yw);
		longint cr, sr, cp, sp, cy, sy;
		quat_t q;
		half_trig(r, cr, sr);
		half_trig(p, cp, sp);
		half_trig(yw, cy, sy);
		q.qx = sat(mul3(sr, cp, cy) - mul3(cr, sp, sy));
		q.qy = sat(mul3(cr, sp, cy) + mul3(sr, cp, sy));
		q.qz = sat(mul3(cr, cp, sy) - mul3(sr, sp, cy));
		q.qw = sat(mul3(cr, cp, cy) + mul3(sr, sp, sy));
		pending.push_back(q);
	endfunction

	function void check_quat(quat_t got);
		quat_t exp_q;
		if (pending.size() == 0) begin
			$error("quaternion with none expected");
			errors++;
			return;
		end
		exp_q = pending.pop_front();
		if (got.qx !== exp_q.qx) begin
			$error("quat_x expected %0d actual %0d", exp_q.qx, got.qx); errors++;
		end
		if (got.qy !== exp_q.qy) begin
			$error("quat_y expected %0d actual %0d", exp_q.qy, got.qy); errors++;
		end
		if (got.qz !== exp_q.qz) begin
			$error("quat_z expected %0d actual %0d", exp_q.qz, got.qz); errors++;
		end
		if (got.qw !== exp_q.qw) begin
			$error("quat_w expected %0d actual %0d", exp_q.qw, got.qw); errors++;
		end
	endfunction
endclass

module tb_top;
	import e2q_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	logic signed [15:0] roll_angle = 0, pitch_angle = 0, yaw_angle = 0;
	logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
	quat_scoreboard board;
	int idle_cycles = 0;

	euler_to_quaternion_unit dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	initial board = new();

	// Output side: a result transfer happens at each edge with done high.
	always @(posedge clk) begin
		quat_t got;
		if (arst_n && done) begin
			got.qx = quat_x; got.qy = quat_y; got.qz = quat_z; got.qw = quat_w;
			board.check_quat(got);
		end
		if (arst_n && ((start && !busy) || done)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic signed [15:0] pick_angle();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
			2: return 16'($urandom_range(0, 64)) - 16'sd32;
			3: return $urandom_range(0, 1) ? 16'sd12868 : -16'sd12868;
			default: return 16'($urandom_range(0, 51472)) - 16'sd25736;
		endcase
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
			: $urandom_range(0, 2);
	endfunction

	// Holds one item on the ports until its transfer, then optionally idles.
	task automatic send_angles(logic signed [15:0] r, logic signed [15:0] p,
			logic signed [15:0] yw, int gap);
		start <= 1;
		roll_angle <= r; pitch_angle <= p; yaw_angle <= yw;
		do @(posedge clk); while (busy);
		board.note_angles(r, p, yw);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		logic signed [15:0] corner[8] = '{16'sh8000, 16'sh7fff, -16'sd25736,
			16'sd25736, 16'sd0, 16'sd12868, -16'sd12868, 16'sd1};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 8; i++) send_angles(corner[i], 0, 0, 0);
		for (int i = 0; i < 8; i++) send_angles(0, corner[i], 0, i % 2);
		for (int i = 0; i < 8; i++) send_angles(corner[i], corner[7 - i], corner[i], 0);
		for (int n = 0; n < 800; n++) begin
			if (n >= 300 && n < 400) send_angles(pick_angle(), pick_angle(), pick_angle(), 0);
			else send_angles(pick_angle(), pick_angle(), pick_angle(), gap_len());
		end
		start <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
